@@ rtl/rgbp_pkg.sv @@
// rgbp_pkg: shared types, character codes, parser phase and status codes
// for the decimal rgb triplet parser; depends on nothing else
`timescale 1ns / 1ps

package rgbp_pkg;

    // character codes
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // value limit and field count
    localparam logic [11:0] MAX_VALUE   = 12'd255;
    localparam logic [2:0]  FIELD_COUNT = 3'd3;

    // per-field character phase
    localparam logic [1:0] PH_LEAD   = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_TRAIL  = 2'd2;

    // first bad field codes
    localparam logic [1:0] BAD_NONE  = 2'd0;
    localparam logic [1:0] BAD_RED   = 2'd1;
    localparam logic [1:0] BAD_GREEN = 2'd2;
    localparam logic [1:0] BAD_BLUE  = 2'd3;

    // result status codes
    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_COUNT     = 3'd1;
    localparam logic [2:0] STATUS_BAD_RED   = 3'd2;
    localparam logic [2:0] STATUS_BAD_GREEN = 3'd3;
    localparam logic [2:0] STATUS_BAD_BLUE  = 3'd4;

    // one input word as held in the input register
    typedef struct packed {
        logic       last;
        logic [7:0] ch;
    } word_t;

    // one result word
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } result_t;

    function automatic logic is_blank(input logic [7:0] c);
        is_blank = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

endpackage

@@ rtl/rgbp_in_stage.sv @@
// rgbp_in_stage: input register for incoming character words
// depends on rgbp_pkg
`timescale 1ns / 1ps

module rgbp_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] ch
    input  logic                 s_axis_tlast,   // end_of_text
    output logic                 word_valid,
    output rgbp_pkg::word_t      word,
    input  logic                 word_take
);
    import rgbp_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    word_t word_reg;

    // free when empty or when the held word moves on this cycle
    assign s_axis_tready = !valid_reg || word_take;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            valid_next = 1'b1;
        end
        else if (word_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            word_reg.ch   <= s_axis_tdata;
            word_reg.last <= s_axis_tlast;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

@@ rtl/rgbp_parse_core.sv @@
// rgbp_parse_core: per-character field parser state and result builder
// depends on rgbp_pkg
`timescale 1ns / 1ps

module rgbp_parse_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 word_valid,
    input  rgbp_pkg::word_t      word,
    input  logic                 out_free,
    output logic                 word_take,
    output logic                 res_load,
    output rgbp_pkg::result_t    res
);
    import rgbp_pkg::*;

    logic [2:0] fields_seen_reg, fields_seen_next;
    logic       field_open_reg,  field_open_next;
    logic [1:0] phase_reg,       phase_next;
    logic [7:0] acc_reg,         acc_next;
    logic       field_bad_reg,   field_bad_next;
    logic [1:0] first_bad_reg,   first_bad_next;
    logic [7:0] red_reg,         red_next;
    logic [7:0] green_reg,       green_next;
    logic [7:0] blue_reg,        blue_next;
    logic [11:0] scaled;
    logic [2:0]  status;

    // a character word always moves; an end word waits for a free output slot
    assign word_take = word_valid && (!word.last || out_free);
    assign res_load  = word_take && word.last;

    // running value times ten plus the new digit
    assign scaled = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + {8'b0, word.ch[3:0]};

    always_comb
    begin
        fields_seen_next = fields_seen_reg;
        field_open_next  = field_open_reg;
        phase_next       = phase_reg;
        acc_next         = acc_reg;
        field_bad_next   = field_bad_reg;
        first_bad_next   = first_bad_reg;
        red_next         = red_reg;
        green_next       = green_reg;
        blue_next        = blue_reg;
        status           = STATUS_OK;
        res              = '0;

        if (word_take)
        begin
            if (word.last || (word.ch == CHAR_COMMA))
            begin
                // close the open field
                if (field_open_reg)
                begin
                    field_open_next = 1'b0;
                    if ((fields_seen_reg != 3'd0) && (fields_seen_reg <= FIELD_COUNT))
                    begin
                        if (field_bad_reg || (phase_reg == PH_LEAD))
                        begin
                            if (first_bad_reg == BAD_NONE)
                            begin
                                first_bad_next = fields_seen_reg[1:0];
                            end
                        end
                        else
                        begin
                            case (fields_seen_reg)
                                3'd1:    red_next   = acc_reg;
                                3'd2:    green_next = acc_reg;
                                default: blue_next  = acc_reg;
                            endcase
                        end
                    end
                end
            end
            else
            begin
                // open a new field on its first character
                if (!field_open_reg)
                begin
                    field_open_next = 1'b1;
                    phase_next      = PH_LEAD;
                    acc_next        = 8'd0;
                    field_bad_next  = 1'b0;
                    if (fields_seen_reg <= FIELD_COUNT)
                    begin
                        fields_seen_next = fields_seen_reg + 3'd1;
                    end
                end

                // character handling by phase
                if (!field_bad_next)
                begin
                    case (phase_next)
                        PH_LEAD:
                        begin
                            if (is_digit(word.ch))
                            begin
                                acc_next   = {4'b0, word.ch[3:0]};
                                phase_next = PH_DIGITS;
                            end
                            else if (!is_blank(word.ch))
                            begin
                                field_bad_next = 1'b1;
                            end
                        end
                        PH_DIGITS:
                        begin
                            if (is_digit(word.ch))
                            begin
                                if (scaled > MAX_VALUE)
                                begin
                                    field_bad_next = 1'b1;
                                end
                                else
                                begin
                                    acc_next = scaled[7:0];
                                end
                            end
                            else if (is_blank(word.ch))
                            begin
                                phase_next = PH_TRAIL;
                            end
                            else
                            begin
                                field_bad_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (!is_blank(word.ch))
                            begin
                                field_bad_next = 1'b1;
                            end
                        end
                    endcase
                end
            end

            // end of line: build the result and clear for the next line
            if (word.last)
            begin
                if (fields_seen_next != FIELD_COUNT)
                begin
                    status = STATUS_COUNT;
                end
                else
                begin
                    case (first_bad_next)
                        BAD_NONE:  status = STATUS_OK;
                        BAD_RED:   status = STATUS_BAD_RED;
                        BAD_GREEN: status = STATUS_BAD_GREEN;
                        default:   status = STATUS_BAD_BLUE;
                    endcase
                end
                res.status = status;
                if (status == STATUS_OK)
                begin
                    res.red   = red_next;
                    res.green = green_next;
                    res.blue  = blue_next;
                end
                fields_seen_next = 3'd0;
                field_open_next  = 1'b0;
                phase_next       = PH_LEAD;
                acc_next         = 8'd0;
                field_bad_next   = 1'b0;
                first_bad_next   = BAD_NONE;
                red_next         = 8'd0;
                green_next       = 8'd0;
                blue_next        = 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fields_seen_reg <= 3'd0;
            field_open_reg  <= 1'b0;
            phase_reg       <= PH_LEAD;
            acc_reg         <= 8'd0;
            field_bad_reg   <= 1'b0;
            first_bad_reg   <= BAD_NONE;
            red_reg         <= 8'd0;
            green_reg       <= 8'd0;
            blue_reg        <= 8'd0;
        end
        else
        begin
            fields_seen_reg <= fields_seen_next;
            field_open_reg  <= field_open_next;
            phase_reg       <= phase_next;
            acc_reg         <= acc_next;
            field_bad_reg   <= field_bad_next;
            first_bad_reg   <= first_bad_next;
            red_reg         <= red_next;
            green_reg       <= green_next;
            blue_reg        <= blue_next;
        end
    end

endmodule

@@ rtl/decimal_rgb_triplet_parser_unit.sv @@
// An end-of-text word passes the input register, and its result is loaded into the
// output register; the end word waits while an earlier result is still held there.
// Throughput: one word per cycle; the input register and the parser state update
// in one pass, and only an end word waits while the output register is held.
// Reset (rst_n low, asynchronous): input and output registers empty, parser state
// cleared to an empty line. Depends on rgbp_pkg, rgbp_in_stage, rgbp_parse_core.
`timescale 1ns / 1ps

module decimal_rgb_triplet_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [7:0] red, [15:8] green, [23:16] blue,
                                        // [26:24] status, [31:27] zero
);
    import rgbp_pkg::*;

    logic    word_valid;
    word_t   word;
    logic    word_take;
    logic    res_load;
    result_t res;
    logic    out_free;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;

    rgbp_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .word_valid    (word_valid),
        .word          (word),
        .word_take     (word_take)
    );

    rgbp_parse_core u_parse_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word       (word),
        .out_free   (out_free),
        .word_take  (word_take),
        .res_load   (res_load),
        .res        (res)
    );

    // output register
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_data_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_data_reg};

    // an end word taken by the parser shows up as a result next cycle
    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> out_valid_reg)
        else $error("end word did not produce a result");

    // an end word never overwrites a result still waiting downstream
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !res_load)
        else $error("result overwritten while stalled");

    // status stays within the defined codes
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.status <= STATUS_BAD_BLUE))
        else $error("status code out of range");

    // colors are zero on any error status
    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.status != STATUS_OK)) |->
        ((out_data_reg.red == 8'd0) && (out_data_reg.green == 8'd0)
         && (out_data_reg.blue == 8'd0)))
        else $error("nonzero color with error status");

    // an empty input register always takes a word
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !word_valid |-> s_axis_tready)
        else $error("input stalled while empty");

endmodule

@@ bench/tb.sv @@
// tb: self-checking bench for decimal_rgb_triplet_parser_unit, drives text lines
// and checks each color result against an untimed parser predictor held here
// depends on rgbp_pkg and the parser rtl
`timescale 1ns / 1ps

module tb;

    import rgbp_pkg::*;

    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam int         DECIMAL_BASE = 10;
    localparam int         RANDOM_WORDS = 1100;
    localparam int         QUIET_LIMIT  = 1000;
    localparam int         DRAIN_CYCLES = 20;

    typedef enum int {FK_GOOD, FK_BLANK_ONLY, FK_MINUS, FK_OVERFLOW, FK_JUNK, FK_SPLIT}
        field_kind_t;

    // one text word waiting to be sent; hold waits for all results first
    typedef struct {
        logic [7:0] ch;
        logic       eot;
        bit         hold;
    } text_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;    // [7:0] ch
    logic        s_axis_tlast = 1'b0;     // end_of_text
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;            // [7:0] red, [15:8] green, [23:16] blue,
                                          // [26:24] status, [31:27] zero

    text_word_t pending_chars[$];
    result_t    expected_colors[$];

    // predictor state
    logic [2:0] line_fields;
    logic       in_field;
    logic [1:0] field_phase;
    logic [7:0] field_acc;
    logic       field_broken;
    logic [1:0] first_broken;
    logic [7:0] held_red;
    logic [7:0] held_green;
    logic [7:0] held_blue;

    int         total_words;
    int         words_sent;
    int         results_predicted;
    int         results_checked;
    int         mismatches;
    int         send_gap;
    int         recv_stall;
    int         quiet_cycles;
    logic       ready_next;
    text_word_t next_word;
    result_t    want_color;
    result_t    seen_color;

    decimal_rgb_triplet_parser_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // character classes
    function automatic logic blank_code(input logic [7:0] c);
        blank_code = (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic logic digit_code(input logic [7:0] c);
        digit_code = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    task automatic clear_line();
        line_fields  = 3'd0;
        in_field     = 1'b0;
        field_phase  = PH_LEAD;
        field_acc    = 8'd0;
        field_broken = 1'b0;
        first_broken = BAD_NONE;
        held_red     = 8'd0;
        held_green   = 8'd0;
        held_blue    = 8'd0;
    endtask

    // close the open field: keep its value or note the first bad one
    task automatic close_open_field();
        if (in_field)
        begin
            in_field = 1'b0;
            if (line_fields != 3'd0 && line_fields <= FIELD_COUNT)
            begin
                if (field_broken || field_phase == PH_LEAD)
                begin
                    // field numbers 1 to 3 line up with the bad field codes
                    if (first_broken == BAD_NONE)
                        first_broken = line_fields[1:0];
                end
                else
                begin
                    case (line_fields[1:0])
                        BAD_RED:   held_red   = field_acc;
                        BAD_GREEN: held_green = field_acc;
                        default:   held_blue  = field_acc;
                    endcase
                end
            end
        end
    endtask

    task automatic parse_char(input logic [7:0] c);
        int next_acc;
        if (c == CHAR_COMMA)
            close_open_field();
        else
        begin
            // first character opens a field, count saturates past three
            if (!in_field)
            begin
                in_field     = 1'b1;
                field_phase  = PH_LEAD;
                field_acc    = 8'd0;
                field_broken = 1'b0;
                if (line_fields <= FIELD_COUNT)
                    line_fields = line_fields + 3'd1;
            end
            if (!field_broken)
            begin
                case (field_phase)
                    PH_LEAD:
                    begin
                        if (digit_code(c))
                        begin
                            field_acc   = c - CHAR_ZERO;
                            field_phase = PH_DIGITS;
                        end
                        else if (!blank_code(c))
                            field_broken = 1'b1;
                    end
                    PH_DIGITS:
                    begin
                        if (digit_code(c))
                        begin
                            next_acc = int'(field_acc) * DECIMAL_BASE + int'(c - CHAR_ZERO);
                            if (next_acc > MAX_VALUE)
                                field_broken = 1'b1;
                            else
                                field_acc = next_acc[7:0];
                        end
                        else if (blank_code(c))
                            field_phase = PH_TRAIL;
                        else
                            field_broken = 1'b1;
                    end
                    default:
                    begin
                        if (!blank_code(c))
                            field_broken = 1'b1;
                    end
                endcase
            end
        end
    endtask

    // end of line: count check first, then first bad field, then values
    task automatic finish_line();
        result_t r;
        close_open_field();
        r = '0;
        if (line_fields != FIELD_COUNT)
            r.status = STATUS_COUNT;
        else
        begin
            case (first_broken)
                BAD_RED:   r.status = STATUS_BAD_RED;
                BAD_GREEN: r.status = STATUS_BAD_GREEN;
                BAD_BLUE:  r.status = STATUS_BAD_BLUE;
                default:
                begin
                    r.status = STATUS_OK;
                    r.red    = held_red;
                    r.green  = held_green;
                    r.blue   = held_blue;
                end
            endcase
        end
        expected_colors.push_back(r);
        results_predicted = results_predicted + 1;
        clear_line();
    endtask

    // stimulus builders
    task automatic push_char(input logic [7:0] c);
        text_word_t w;
        w.ch   = c;
        w.eot  = 1'b0;
        w.hold = 1'b0;
        pending_chars.push_back(w);
    endtask

    task automatic push_end();
        text_word_t w;
        w.ch   = 8'($urandom_range(0, 255));
        w.eot  = 1'b1;
        w.hold = 1'b0;
        pending_chars.push_back(w);
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    function automatic logic [7:0] blank_char();
        if ($urandom_range(0, 1) == 0)
            blank_char = CHAR_SPACE;
        else
            blank_char = 8'($urandom_range(CHAR_TAB, CHAR_CR));
    endfunction

    task automatic push_blanks(input int n);
        repeat (n) push_char(blank_char());
    endtask

    task automatic push_commas(input int n);
        repeat (n) push_char(CHAR_COMMA);
    endtask

    task automatic push_number(input int v);
        int div;
        // occasional leading zeros
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) push_char(CHAR_ZERO);
        div = 1;
        while (div * DECIMAL_BASE <= v)
            div = div * DECIMAL_BASE;
        while (div > 0)
        begin
            push_char(CHAR_ZERO + 8'((v / div) % DECIMAL_BASE));
            div = div / DECIMAL_BASE;
        end
    endtask

    function automatic int color_value();
        case ($urandom_range(0, 9))
            0:       color_value = 0;
            1:       color_value = 255;
            default: color_value = $urandom_range(0, 255);
        endcase
    endfunction

    function automatic logic [7:0] noise_char();
        case ($urandom_range(0, 4))
            0:       noise_char = CHAR_COMMA;
            1:       noise_char = CHAR_ZERO + 8'($urandom_range(0, 9));
            2:       noise_char = blank_char();
            3:       noise_char = CHAR_MINUS;
            default: noise_char = 8'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic push_field(input field_kind_t kind);
        push_blanks($urandom_range(0, 2));
        case (kind)
            FK_GOOD:       push_number(color_value());
            FK_BLANK_ONLY: push_blanks($urandom_range(1, 2));
            FK_MINUS:
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    push_char(CHAR_MINUS);
                    push_number(color_value());
                end
                else
                begin
                    push_number(color_value());
                    push_char(CHAR_MINUS);
                end
            end
            FK_OVERFLOW:   push_number($urandom_range(256, 9999));
            FK_JUNK:
            begin
                push_number(color_value());
                push_char(noise_char());
                if ($urandom_range(0, 1) == 0)
                    push_number(color_value());
            end
            default:
            begin
                push_number(color_value());
                push_blanks($urandom_range(1, 2));
                push_number(color_value());
            end
        endcase
        push_blanks($urandom_range(0, 2));
    endtask

    // one random line: mostly well formed, some broken, some noise
    task automatic push_line();
        int          shape;
        int          nfields;
        int          k;
        int          start;
        field_kind_t kind;
        start = pending_chars.size();
        shape = $urandom_range(0, 9);
        if (shape == 9)
            repeat ($urandom_range(0, 12)) push_char(noise_char());
        else
        begin
            nfields = (shape < 7) ? 3 : $urandom_range(0, 5);
            if ($urandom_range(0, 3) == 0)
                push_commas($urandom_range(1, 2));
            for (k = 0; k < nfields; k++)
            begin
                if (k > 0)
                    push_commas(($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1);
                if (shape < 7 || $urandom_range(0, 1) == 0)
                    kind = FK_GOOD;
                else
                    kind = field_kind_t'($urandom_range(FK_BLANK_ONLY, FK_SPLIT));
                push_field(kind);
            end
            if ($urandom_range(0, 3) == 0)
                push_commas($urandom_range(1, 2));
        end
        push_end();
        if ($urandom_range(0, 19) == 0)
            pending_chars[start].hold = 1'b1;
    endtask

    // directed lines, random lines, then release reset and wait for the end
    initial
    begin
        int start;
        clear_line();
        total_words       = 0;
        words_sent        = 0;
        results_predicted = 0;
        mismatches        = 0;
        send_gap          = 0;
        recv_stall        = 0;
        quiet_cycles      = 0;

        // extremes, tab blank and leading zeros
        push_text("255,\t007,0");
        push_end();
        // blank-only field, minus before zero, junk char, more than three fields
        push_text(" ,-0,2x9,5");
        push_end();
        // character code zero in green, sent once the line above is answered
        start = pending_chars.size();
        push_text("9,");
        push_char(8'h00);
        push_text(",1");
        pending_chars[start].hold = 1'b1;
        push_end();
        // empty line
        push_end();

        while (pending_chars.size() < RANDOM_WORDS + 29)
            push_line();
        total_words = pending_chars.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (!(words_sent == total_words && results_checked == results_predicted));
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (expected_colors.size() != 0)
        begin
            $error("results missing: %0d expected colors left", expected_colors.size());
            mismatches = mismatches + 1;
        end
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // driver: predict on each accepted word, then present the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tlast  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tlast)
                    finish_line();
                else
                    parse_char(s_axis_tdata);
                words_sent = words_sent + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap = send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_chars.size() > 0 &&
                         (!pending_chars[0].hold || results_checked == results_predicted))
                begin
                    next_word = pending_chars.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_word.ch;
                    s_axis_tlast  <= next_word.eot;
                    // every fourth stretch of words goes back to back
                    if ((words_sent / 150) % 4 == 2)
                        send_gap = 0;
                    else
                        send_gap = $urandom_range(0, 15);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: check each result word against the oldest expected color
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready   <= 1'b0;
            results_checked <= 0;
        end
        else
        begin
            ready_next = m_axis_tready;
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen_color = m_axis_tdata[26:0];
                if (expected_colors.size() == 0)
                begin
                    $error("unexpected result word %h", m_axis_tdata);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want_color = expected_colors.pop_front();
                    if (seen_color.red !== want_color.red)
                    begin
                        $error("red: expected %0d, actual %0d", want_color.red, seen_color.red);
                        mismatches = mismatches + 1;
                    end
                    if (seen_color.green !== want_color.green)
                    begin
                        $error("green: expected %0d, actual %0d",
                               want_color.green, seen_color.green);
                        mismatches = mismatches + 1;
                    end
                    if (seen_color.blue !== want_color.blue)
                    begin
                        $error("blue: expected %0d, actual %0d",
                               want_color.blue, seen_color.blue);
                        mismatches = mismatches + 1;
                    end
                    if (seen_color.status !== want_color.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               want_color.status, seen_color.status);
                        mismatches = mismatches + 1;
                    end
                    if (m_axis_tdata[31:27] !== 5'd0)
                    begin
                        $error("pad: expected 0, actual %0d", m_axis_tdata[31:27]);
                        mismatches = mismatches + 1;
                    end
                end
                results_checked <= results_checked + 1;
                // some stretches of results are taken without stalls
                if ((results_checked / 8) % 3 == 1)
                    recv_stall = 0;
                else
                    recv_stall = $urandom_range(0, 15);
                ready_next = (recv_stall == 0);
            end
            else if (!m_axis_tready)
            begin
                if (recv_stall > 0)
                    recv_stall = recv_stall - 1;
                ready_next = (recv_stall == 0);
            end
            m_axis_tready <= ready_next;
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

endmodule
